@@ rtl/pfl_pkg.sv @@
// Package: shared types and constants of the polygon face-list parser.
`default_nettype none
package pfl_pkg;

    localparam int COUNT_BITS = 10;
    localparam int FLAG_BITS  = 6;
    localparam int INDEX_BITS = 24;
    localparam int OUT_CNT_BITS = 10;

    localparam logic [7:0] MARKER_BYTE = 8'hFF;

    typedef logic [COUNT_BITS-1:0]   t_count;
    typedef logic [FLAG_BITS-1:0]    t_flags;
    typedef logic [INDEX_BITS-1:0]   t_index;
    typedef logic [OUT_CNT_BITS-1:0] t_out_cnt;

    typedef enum logic [1:0] {
        PH_HDR_HI    = 2'd0,
        PH_HDR_LO    = 2'd1,
        PH_IDX_FIRST = 2'd2,
        PH_IDX_REST  = 2'd3
    } t_phase;

    localparam logic [1:0] ST_INDEX = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

endpackage
`default_nettype wire

@@ rtl/pfl_if.sv @@
// Interfaces: byte input channel and result output channel.
`default_nettype none
interface pfl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       chunk_end;

    modport source (output valid, output data_byte, output chunk_end, input ready);
    modport sink   (input valid, input data_byte, input chunk_end, output ready);
endinterface

interface pfl_out_if;
    logic                valid;
    logic                ready;
    pfl_pkg::t_index     vertex_index;
    pfl_pkg::t_index     polygon_number;
    pfl_pkg::t_out_cnt   vertex_position;
    pfl_pkg::t_out_cnt   vertex_count;
    pfl_pkg::t_flags     polygon_flags;
    logic                last_of_polygon;
    logic [1:0]          status;

    modport source (output valid, output vertex_index, output polygon_number,
                    output vertex_position, output vertex_count, output polygon_flags,
                    output last_of_polygon, output status, input ready);
    modport sink   (input valid, input vertex_index, input polygon_number,
                    input vertex_position, input vertex_count, input polygon_flags,
                    input last_of_polygon, input status, output ready);
endinterface
`default_nettype wire

@@ rtl/polygon_face_list_parser.sv @@
// Top level: byte-serial parser of polygon face-list chunk bodies.
//
//  channel | dir | payload                                   | transfer when
//  i_in    | in  | data_byte, chunk_end                      | valid & ready
//  o_out   | out | vertex_index, polygon_number, position,   | valid & ready
//          |     | count, flags, last_of_polygon, status     |
//
// One byte per cycle while the input is ready; a result is registered as its completing byte is taken.
// Throughput is set by the single output register: a new byte is taken
// whenever that register is empty or being drained in the same cycle.
// Synchronous active-low reset returns the parser to header-high phase.
// chunk_end on any byte restarts parsing with polygon number zero.
`default_nettype none
module polygon_face_list_parser (
    input  wire             i_clk,
    input  wire             i_rst_n,
    pfl_in_if.sink          i_in,
    pfl_out_if.source       o_out
);

    pfl_pkg::t_phase r_phase, n_phase;
    pfl_pkg::t_index r_shift, n_shift;
    logic [1:0]      r_left, n_left;
    pfl_pkg::t_count r_count, n_count;
    pfl_pkg::t_flags r_flags, n_flags;
    pfl_pkg::t_count r_pos, n_pos;
    pfl_pkg::t_index r_poly, n_poly;

    logic            r_out_valid;
    pfl_pkg::t_index r_vidx, n_vidx;
    pfl_pkg::t_index r_pnum;
    pfl_pkg::t_count r_vpos, n_vpos;
    pfl_pkg::t_count r_vcnt, n_vcnt;
    pfl_pkg::t_flags r_vflg, n_vflg;
    logic            r_last, n_last;
    logic [1:0]      r_stat, n_stat;
    logic            n_emit;

    logic            accept;
    logic [15:0]     hdr;
    pfl_pkg::t_count hdr_count;
    pfl_pkg::t_flags hdr_flags;
    pfl_pkg::t_index shift_in;
    logic [1:0]      left_dec;
    pfl_pkg::t_count pos_inc;
    logic            is_last;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    assign hdr       = {r_shift[7:0], i_in.data_byte};
    assign hdr_count = pfl_pkg::t_count'(hdr);
    assign hdr_flags = pfl_pkg::t_flags'(hdr >> pfl_pkg::COUNT_BITS);
    assign shift_in  = pfl_pkg::t_index'({r_shift, i_in.data_byte});
    assign left_dec  = r_left - 2'd1;
    assign pos_inc   = r_pos + pfl_pkg::t_count'(1);
    assign is_last   = (pos_inc == r_count);

    always_comb begin
        n_phase = r_phase;
        n_shift = r_shift;
        n_left  = r_left;
        n_count = r_count;
        n_flags = r_flags;
        n_pos   = r_pos;
        n_poly  = r_poly;
        n_emit  = 1'b0;
        n_vidx  = '0;
        n_vpos  = r_pos;
        n_vcnt  = r_count;
        n_vflg  = r_flags;
        n_last  = 1'b1;
        n_stat  = pfl_pkg::ST_TRUNC;

        unique case (r_phase)
            pfl_pkg::PH_HDR_LO: begin
                n_count = hdr_count;
                n_flags = hdr_flags;
                n_pos   = '0;
                n_shift = '0;
                n_vpos  = '0;
                n_vcnt  = hdr_count;
                n_vflg  = hdr_flags;
                if (hdr_count == '0) begin
                    n_emit  = 1'b1;
                    n_stat  = pfl_pkg::ST_EMPTY;
                    n_poly  = r_poly + pfl_pkg::t_index'(1);
                    n_phase = pfl_pkg::PH_HDR_HI;
                    n_left  = '0;
                    n_count = '0;
                    n_flags = '0;
                end else if (i_in.chunk_end) begin
                    n_emit = 1'b1;
                end else begin
                    n_phase = pfl_pkg::PH_IDX_FIRST;
                end
            end
            pfl_pkg::PH_IDX_FIRST: begin
                if (i_in.data_byte == pfl_pkg::MARKER_BYTE) begin
                    n_shift = '0;
                    n_left  = 2'd3;
                end else begin
                    n_shift = pfl_pkg::t_index'(i_in.data_byte);
                    n_left  = 2'd1;
                end
                n_phase = pfl_pkg::PH_IDX_REST;
                n_emit  = i_in.chunk_end;
            end
            pfl_pkg::PH_IDX_REST: begin
                n_shift = shift_in;
                n_left  = left_dec;
                if (left_dec == 2'd0) begin
                    n_emit = 1'b1;
                    if (!(i_in.chunk_end && !is_last)) begin
                        n_vidx = shift_in;
                        n_last = is_last;
                        n_stat = pfl_pkg::ST_INDEX;
                        if (is_last) begin
                            n_poly  = r_poly + pfl_pkg::t_index'(1);
                            n_phase = pfl_pkg::PH_HDR_HI;
                            n_shift = '0;
                            n_left  = '0;
                            n_count = '0;
                            n_flags = '0;
                            n_pos   = '0;
                        end else begin
                            n_pos   = pos_inc;
                            n_shift = '0;
                            n_phase = pfl_pkg::PH_IDX_FIRST;
                        end
                    end
                end else begin
                    n_emit = i_in.chunk_end;
                end
            end
            default: begin
                n_count = '0;
                n_flags = '0;
                n_pos   = '0;
                n_left  = '0;
                n_shift = pfl_pkg::t_index'(i_in.data_byte);
                n_phase = pfl_pkg::PH_HDR_LO;
                n_vpos  = '0;
                n_vcnt  = '0;
                n_vflg  = '0;
                n_emit  = i_in.chunk_end;
            end
        endcase

        if (i_in.chunk_end) begin
            n_phase = pfl_pkg::PH_HDR_HI;
            n_shift = '0;
            n_left  = '0;
            n_count = '0;
            n_flags = '0;
            n_pos   = '0;
            n_poly  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= pfl_pkg::PH_HDR_HI;
            r_shift     <= '0;
            r_left      <= '0;
            r_count     <= '0;
            r_flags     <= '0;
            r_pos       <= '0;
            r_poly      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_shift     <= n_shift;
                r_left      <= n_left;
                r_count     <= n_count;
                r_flags     <= n_flags;
                r_pos       <= n_pos;
                r_poly      <= n_poly;
                r_out_valid <= n_emit;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload; polygon number is sampled before any increment
    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_vidx <= n_vidx;
            r_pnum <= r_poly;
            r_vpos <= n_vpos;
            r_vcnt <= n_vcnt;
            r_vflg <= n_vflg;
            r_last <= n_last;
            r_stat <= n_stat;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.vertex_index    = r_vidx;
    assign o_out.polygon_number  = r_pnum;
    assign o_out.vertex_position = pfl_pkg::t_out_cnt'(r_vpos);
    assign o_out.vertex_count    = pfl_pkg::t_out_cnt'(r_vcnt);
    assign o_out.polygon_flags   = r_vflg;
    assign o_out.last_of_polygon = r_last;
    assign o_out.status          = r_stat;

endmodule
`default_nettype wire

@@ tb/sv/tb_polygon_face_list_parser.sv @@
// Testbench: polygon face-list parser driven with directed and random byte chunks, results scoreboarded.
`timescale 1ns / 1ps
module tb_polygon_face_list_parser;

    localparam int HOLD_CYCLES   = 200;
    localparam int RANDOM_BYTES  = 800;
    localparam int CALM_BYTES    = 650;
    localparam int HOLD_AT_BYTES = 250;
    localparam int TAIL_CYCLES   = 10;
    localparam int BIG_CUT_BYTES = 40;

    typedef struct packed {
        pfl_pkg::t_index   vertex_index;
        pfl_pkg::t_index   polygon_number;
        pfl_pkg::t_out_cnt vertex_position;
        pfl_pkg::t_out_cnt vertex_count;
        pfl_pkg::t_flags   polygon_flags;
        logic              last_of_polygon;
        logic [1:0]        status;
    } t_face_result;

    class face_scoreboard;
        t_face_result    face_q[$];
        int              errors;
        pfl_pkg::t_phase phase;
        pfl_pkg::t_index shift_val;
        logic [1:0]      bytes_left;
        pfl_pkg::t_count vert_count;
        pfl_pkg::t_flags poly_flags;
        pfl_pkg::t_count next_pos;
        pfl_pkg::t_index poly_num;

        function new();
            errors = 0;
            poly_num = '0;
            clear_polygon();
        endfunction

        function void clear_polygon();
            phase = pfl_pkg::PH_HDR_HI;
            shift_val = '0;
            bytes_left = '0;
            vert_count = '0;
            poly_flags = '0;
            next_pos = '0;
        endfunction

        function void push_face(pfl_pkg::t_index idx, pfl_pkg::t_count pos, logic last,
                                logic [1:0] st);
            t_face_result r;
            r.vertex_index    = idx;
            r.polygon_number  = poly_num;
            r.vertex_position = pfl_pkg::t_out_cnt'(pos);
            r.vertex_count    = pfl_pkg::t_out_cnt'(vert_count);
            r.polygon_flags   = poly_flags;
            r.last_of_polygon = last;
            r.status          = st;
            face_q = {face_q, r};
        endfunction

        // one accepted byte of the chunk body
        function void note_byte(logic [7:0] b, logic chunk_end);
            logic [15:0] hdr;
            logic        last;
            case (phase)
                pfl_pkg::PH_HDR_LO: begin
                    hdr = {shift_val[7:0], b};
                    vert_count = pfl_pkg::t_count'(hdr);
                    poly_flags = pfl_pkg::t_flags'(hdr >> pfl_pkg::COUNT_BITS);
                    next_pos = '0;
                    shift_val = '0;
                    if (vert_count == '0) begin
                        push_face('0, '0, 1'b1, pfl_pkg::ST_EMPTY);
                        poly_num = poly_num + pfl_pkg::t_index'(1);
                        clear_polygon();
                    end else if (chunk_end) begin
                        push_face('0, '0, 1'b1, pfl_pkg::ST_TRUNC);
                    end else begin
                        phase = pfl_pkg::PH_IDX_FIRST;
                    end
                end
                pfl_pkg::PH_IDX_FIRST: begin
                    if (b == pfl_pkg::MARKER_BYTE) begin
                        shift_val = '0;
                        bytes_left = 2'd3;
                    end else begin
                        shift_val = pfl_pkg::t_index'(b);
                        bytes_left = 2'd1;
                    end
                    phase = pfl_pkg::PH_IDX_REST;
                    if (chunk_end) push_face('0, next_pos, 1'b1, pfl_pkg::ST_TRUNC);
                end
                pfl_pkg::PH_IDX_REST: begin
                    shift_val = {shift_val[15:0], b};
                    bytes_left = bytes_left - 2'd1;
                    if (bytes_left == '0) begin
                        last = (pfl_pkg::t_count'(next_pos + pfl_pkg::t_count'(1)) == vert_count);
                        if (chunk_end && !last) begin
                            push_face('0, next_pos, 1'b1, pfl_pkg::ST_TRUNC);
                        end else begin
                            push_face(shift_val, next_pos, last, pfl_pkg::ST_INDEX);
                            if (last) begin
                                poly_num = poly_num + pfl_pkg::t_index'(1);
                                clear_polygon();
                            end else begin
                                next_pos = next_pos + pfl_pkg::t_count'(1);
                                shift_val = '0;
                                phase = pfl_pkg::PH_IDX_FIRST;
                            end
                        end
                    end else if (chunk_end) begin
                        push_face('0, next_pos, 1'b1, pfl_pkg::ST_TRUNC);
                    end
                end
                default: begin
                    vert_count = '0;
                    poly_flags = '0;
                    next_pos = '0;
                    bytes_left = '0;
                    shift_val = pfl_pkg::t_index'(b);
                    phase = pfl_pkg::PH_HDR_LO;
                    if (chunk_end) push_face('0, '0, 1'b1, pfl_pkg::ST_TRUNC);
                end
            endcase
            if (chunk_end) begin
                clear_polygon();
                poly_num = '0;
            end
        endfunction

        function void cmp_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_face_result act);
            t_face_result exp_r;
            if (face_q.size() == 0) begin
                $display("%0t: unexpected result: expected none actual %p", $time, act);
                errors++;
                return;
            end
            exp_r = face_q.pop_front();
            cmp_field("vertex_index", exp_r.vertex_index, act.vertex_index);
            cmp_field("polygon_number", exp_r.polygon_number, act.polygon_number);
            cmp_field("vertex_position", exp_r.vertex_position, act.vertex_position);
            cmp_field("vertex_count", exp_r.vertex_count, act.vertex_count);
            cmp_field("polygon_flags", exp_r.polygon_flags, act.polygon_flags);
            cmp_field("last_of_polygon", exp_r.last_of_polygon, act.last_of_polygon);
            cmp_field("status", exp_r.status, act.status);
        endfunction

        function int pending();
            return face_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   calm = 1'b0;
    bit   hold_req = 1'b0;
    int   bytes_sent = 0;

    logic [7:0]     chunk_bytes[$];
    face_scoreboard sb;

    pfl_in_if  in_ch ();
    pfl_out_if out_ch ();

    polygon_face_list_parser dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #1 clk = ~clk;

    task automatic send_byte(input logic [7:0] b, input logic chunk_end);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.chunk_end <= chunk_end;
        @(negedge clk);
        while (!in_ch.ready) @(negedge clk);
        @(posedge clk);
        bytes_sent++;
    endtask

    // sends the first n_bytes of the built chunk, chunk end on the last one
    task automatic send_chunk(input int n_bytes);
        for (int i = 0; i < n_bytes; i++)
            send_byte(chunk_bytes[i], i == n_bytes - 1);
        chunk_bytes.delete();
    endtask

    function automatic void add_byte(logic [7:0] b);
        chunk_bytes = {chunk_bytes, b};
    endfunction

    function automatic void add_polygon(int unsigned n_vert, int unsigned wide_pct);
        logic [15:0] hdr;
        hdr = 16'($urandom);
        hdr[pfl_pkg::COUNT_BITS-1:0] = pfl_pkg::t_count'(n_vert);
        add_byte(hdr[15:8]);
        add_byte(hdr[7:0]);
        for (int unsigned v = 0; v < n_vert; v++) begin
            if ($urandom_range(0, 99) < wide_pct) begin
                add_byte(pfl_pkg::MARKER_BYTE);
                repeat (3) add_byte(8'($urandom));
            end else begin
                add_byte(8'($urandom_range(0, 254)));
                add_byte(8'($urandom));
            end
        end
    endfunction

    function automatic int unsigned pick_count();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel < 2) return 0;
        if (sel == 2) return $urandom_range(7, 100);
        return $urandom_range(1, 6);
    endfunction

    task automatic random_chunk();
        int unsigned kind;
        kind = $urandom_range(0, 7);
        if (kind == 0) begin
            // noise, with chunk ends scattered anywhere
            for (int i = $urandom_range(1, 12); i > 1; i--)
                send_byte(8'($urandom), $urandom_range(0, 7) == 0);
            send_byte(8'($urandom), 1'b1);
        end else begin
            repeat ($urandom_range(1, 6)) add_polygon(pick_count(), 30);
            if (kind == 1)
                send_chunk($urandom_range(1, chunk_bytes.size()));
            else
                send_chunk(chunk_bytes.size());
        end
    endtask

    always @(negedge clk) begin
        t_face_result act;
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                act.vertex_index    = out_ch.vertex_index;
                act.polygon_number  = out_ch.polygon_number;
                act.vertex_position = out_ch.vertex_position;
                act.vertex_count    = out_ch.vertex_count;
                act.polygon_flags   = out_ch.polygon_flags;
                act.last_of_polygon = out_ch.last_of_polygon;
                act.status          = out_ch.status;
                sb.check_result(act);
            end
            if (in_ch.valid && in_ch.ready)
                sb.note_byte(in_ch.data_byte, in_ch.chunk_end);
        end
    end

    // result sink: random stalls, one long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial begin
        int start_bytes;
        bit hold_done;
        sb = new();
        hold_done = 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= '0;
        in_ch.chunk_end <= 1'b0;
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty polygon closing the chunk
        chunk_bytes = '{8'h00, 8'h00};
        send_chunk(2);
        // empty polygon with all flags, then full count/flags cut on header low byte
        chunk_bytes = '{8'hFC, 8'h00, 8'hFF, 8'hFF};
        send_chunk(4);
        // wide index of all ones, then narrow zero index
        chunk_bytes = '{8'h04, 8'h02, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00};
        send_chunk(8);
        // chunk end on header high byte
        chunk_bytes = '{8'h12};
        send_chunk(1);
        // cut inside a wide index
        chunk_bytes = '{8'h00, 8'h01, 8'hFF, 8'h12};
        send_chunk(4);
        // cut on first index byte
        chunk_bytes = '{8'h00, 8'h01, 8'hAB};
        send_chunk(3);
        // cut where a non-last index completes
        chunk_bytes = '{8'h00, 8'h02, 8'h12, 8'h34};
        send_chunk(4);

        // polygon of the largest count, cut after its first indices
        add_polygon(1023, 10);
        send_chunk(BIG_CUT_BYTES);

        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES) begin
            if (!hold_done && bytes_sent - start_bytes >= HOLD_AT_BYTES) begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (bytes_sent - start_bytes >= CALM_BYTES) calm = 1'b1;
            random_chunk();
        end
        in_ch.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS polygon_face_list_parser");
        else
            $display("FAIL polygon_face_list_parser");
        $finish;
    end

    initial begin
        #1000000;
        $display("FAIL polygon_face_list_parser");
        $finish;
    end

endmodule
